// File: hw/rtl/vrp_pkg.sv
// ----------------------------------------------------------------------------
// vrp_pkg
// shared types, constants and rounding helpers for the vertex rotate/project
// block
// ----------------------------------------------------------------------------
`default_nettype none

package vrp_pkg;

    localparam int COORD_W  = 16;
    localparam int SCREEN_W = 12;
    localparam int SCR_W    = 16;
    localparam int DIV_LAT  = 18;

    // angle constants, Q.13
    localparam logic signed [17:0] Q_PI      = 18'sd25736;
    localparam logic signed [17:0] Q_TWO_PI  = 18'sd51472;
    localparam logic signed [17:0] Q_HALF_PI = 18'sd12868;

    // parabola coefficients, scaled by 2^16
    localparam logic signed [47:0] K_FOUR_PI_S = 48'sd683565056; // 83443 * 8192
    localparam logic signed [47:0] K_FOUR_PI2  = 48'sd26561;
    localparam logic signed [47:0] K_CORR      = 48'sd14746;

    // configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_YAW    = 3'd0;
    localparam t_cfg_idx CFG_PITCH  = 3'd1;
    localparam t_cfg_idx CFG_DIST   = 3'd2;
    localparam t_cfg_idx CFG_WIDTH  = 3'd3;
    localparam t_cfg_idx CFG_HEIGHT = 3'd4;

    typedef enum logic {
        T_IDLE,
        T_RUN
    } t_trig_state;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
        logic               last_vertex;
    } t_vertex;

    typedef struct packed {
        logic signed [15:0] camera_x;
        logic signed [15:0] camera_y;
        logic signed [15:0] camera_z;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               bad_depth;
        logic               last_out;
    } t_result;

    typedef struct packed {
        logic signed [15:0] sin_yaw;
        logic signed [15:0] cos_yaw;
        logic signed [15:0] sin_pitch;
        logic signed [15:0] cos_pitch;
    } t_trig;

    // round to nearest, halves away from zero, drop 13 bits
    function automatic logic signed [24:0] rnd13(input logic signed [37:0] v);
        logic [37:0] mag;
        logic [37:0] r;
        mag = v[37] ? 38'(-v) : 38'(v);
        r   = (mag + 38'd4096) >> 13;
        return v[37] ? -$signed(r[24:0]) : $signed(r[24:0]);
    endfunction

    // same rounding, drop 29 bits
    function automatic logic signed [19:0] rnd29(input logic signed [47:0] v);
        logic [47:0] mag;
        logic [47:0] r;
        mag = v[47] ? 48'(-v) : 48'(v);
        r   = (mag + 48'd268435456) >> 29;
        return v[47] ? -$signed(r[19:0]) : $signed(r[19:0]);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) begin
            return 16'sh7fff;
        end else if (v < -20'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/vrp_trig.sv
// ----------------------------------------------------------------------------
// vrp_trig
// sequential parabolic sine/cosine of yaw and pitch, one shared datapath
// ----------------------------------------------------------------------------
`default_nettype none

module vrp_trig
    import vrp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_restart,
    input  wire logic signed [15:0] i_yaw,
    input  wire logic signed [14:0] i_pitch,
    output t_trig                   o_trig,
    output logic                    o_busy
);

    t_trig_state r_state, n_state;
    logic [2:0]  r_step, n_step;
    logic [1:0]  r_idx, n_idx;

    logic signed [17:0] r_a;
    logic signed [47:0] r_m1;
    logic signed [31:0] r_m2;
    logic signed [47:0] r_m3;
    logic signed [15:0] r_par;
    logic signed [47:0] r_pp;
    logic signed [47:0] r_c;
    logic signed [15:0] r_sc [4];

    logic signed [17:0] raw_ang;
    logic signed [17:0] wrap1;
    logic signed [17:0] wrap2;
    logic signed [17:0] a_mag;
    logic signed [15:0] par_mag;
    logic signed [19:0] par_full;
    logic signed [19:0] corr_full;

    always_comb begin
        unique case (r_idx)
            2'd0:    raw_ang = 18'(i_yaw);
            2'd1:    raw_ang = 18'(i_yaw) + Q_HALF_PI;
            2'd2:    raw_ang = 18'(i_pitch);
            default: raw_ang = 18'(i_pitch) + Q_HALF_PI;
        endcase
        wrap1     = (raw_ang > Q_PI) ? raw_ang - Q_TWO_PI : raw_ang;
        wrap2     = (wrap1 < -Q_PI) ? wrap1 + Q_TWO_PI : wrap1;
        a_mag     = r_a[17] ? -r_a : r_a;
        par_mag   = r_par[15] ? -r_par : r_par;
        par_full  = rnd29(r_m1 - r_m3);
        corr_full = rnd29(r_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_RUN;
            r_step  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_idx   = r_idx;
        unique case (r_state)
            T_IDLE: begin
                n_step = '0;
                n_idx  = '0;
            end
            T_RUN: begin
                if (r_step == 3'd6) begin
                    n_step = '0;
                    n_idx  = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        n_state = T_IDLE;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            default: n_state = T_IDLE;
        endcase
        if (i_restart) begin
            n_state = T_RUN;
            n_step  = '0;
            n_idx   = '0;
        end
    end

    // one step of the sine evaluation per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == T_RUN) begin
            case (r_step)
                3'd0: r_a <= wrap2;
                3'd1: begin
                    r_m1 <= 48'(r_a) * K_FOUR_PI_S;
                    r_m2 <= 32'(r_a * a_mag);
                end
                3'd2: r_m3 <= 48'(r_m2) * K_FOUR_PI2;
                3'd3: r_par <= par_full[15:0];
                3'd4: r_pp <= 48'(r_par) * 48'(par_mag) - (48'(r_par) <<< 13);
                3'd5: r_c <= r_pp * K_CORR;
                3'd6: r_sc[r_idx] <= r_par + corr_full[15:0];
                default: ;
            endcase
        end
    end

    assign o_trig.sin_yaw   = r_sc[0];
    assign o_trig.cos_yaw   = r_sc[1];
    assign o_trig.sin_pitch = r_sc[2];
    assign o_trig.cos_pitch = r_sc[3];
    assign o_busy           = (r_state == T_RUN);

endmodule

`default_nettype wire

// File: hw/rtl/vrp_div.sv
// ----------------------------------------------------------------------------
// vrp_div
// pipelined signed-by-positive divider, one quotient bit per stage,
// quotient truncated toward zero and saturated to 16 bits
// ----------------------------------------------------------------------------
`default_nettype none

module vrp_div
    import vrp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic signed [39:0] i_num,
    input  wire logic        [25:0] i_den,
    output logic signed [15:0]      o_quot
);

    localparam int STEPS = 16;

    logic [41:0] r_rem [STEPS+1];
    logic [15:0] r_q   [STEPS+1];
    logic [41:0] r_den [STEPS+1];
    logic        r_neg [STEPS+1];
    logic        r_ovf [STEPS+1];
    logic signed [15:0] r_out;

    logic [41:0] in_mag;
    logic [41:0] in_den;

    assign in_mag = i_num[39] ? 42'($unsigned(-i_num)) : 42'($unsigned(i_num));
    assign in_den = 42'(i_den);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= in_mag;
        r_q[0]   <= '0;
        r_den[0] <= in_den;
        r_neg[0] <= i_num[39];
        r_ovf[0] <= (in_mag >= (in_den << STEPS));
        for (int i = 0; i < STEPS; i++) begin
            if (r_rem[i] >= (r_den[i] << (STEPS - 1 - i))) begin
                r_rem[i+1] <= r_rem[i] - (r_den[i] << (STEPS - 1 - i));
                r_q[i+1]   <= {r_q[i][14:0], 1'b1};
            end else begin
                r_rem[i+1] <= r_rem[i];
                r_q[i+1]   <= {r_q[i][14:0], 1'b0};
            end
            r_den[i+1] <= r_den[i];
            r_neg[i+1] <= r_neg[i];
            r_ovf[i+1] <= r_ovf[i];
        end
        if (r_ovf[STEPS]) begin
            r_out <= r_neg[STEPS] ? 16'sh8000 : 16'sh7fff;
        end else if (!r_neg[STEPS]) begin
            r_out <= r_q[STEPS][15] ? 16'sh7fff : $signed(r_q[STEPS]);
        end else if (r_q[STEPS] > 16'd32768) begin
            r_out <= 16'sh8000;
        end else begin
            r_out <= -$signed(r_q[STEPS]);
        end
    end

    assign o_quot = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/vertex_rotate_project.sv
// ----------------------------------------------------------------------------
// vertex_rotate_project
// yaw/pitch rotation of a model vertex followed by perspective projection
// ----------------------------------------------------------------------------
//  channel  | signals                                | direction
//  ---------+----------------------------------------+-----------
//  vertex   | start, busy, i_vertex                  | in
//  result   | o_result_valid, o_result               | out
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_index, | in
//           | i_cfg_data                             |
//
//  one vertex per cycle while busy is low; each result passes through the
//  8 rotate/scale stages and then the 18-stage quotient pipeline
//  after reset and after each yaw or pitch write the sine/cosine sequencer
//  runs 7 steps for each of the four values with busy high
//  the result strobe lasts one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_rotate_project
    import vrp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_vertex  i_vertex,
    output logic          o_result_valid,
    output t_result       o_result,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire t_cfg_idx i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int SB_LAST = 2 + DIV_LAT;

    typedef struct packed {
        logic signed [15:0] cam_x;
        logic signed [15:0] cam_y;
        logic signed [15:0] cam_z;
        logic               bad;
        logic               last;
    } t_side;

    // configuration registers
    logic signed [15:0]  r_yaw;
    logic signed [14:0]  r_pitch;
    logic [15:0]         r_dist;
    logic [SCREEN_W-1:0] r_wid;
    logic [SCREEN_W-1:0] r_hgt;

    logic  cfg_wr;
    logic  trig_restart;
    logic  trig_busy;
    t_trig trig;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr       = i_cfg_valid & o_cfg_ready;
    assign trig_restart = cfg_wr & ((i_cfg_index == CFG_YAW) || (i_cfg_index == CFG_PITCH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw   <= 16'sd3277;
            r_pitch <= -15'sd1638;
            r_dist  <= 16'd14336;
            r_wid   <= SCREEN_W'(960);
            r_hgt   <= SCREEN_W'(640);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_YAW:    r_yaw   <= i_cfg_data;
                CFG_PITCH:  r_pitch <= i_cfg_data[14:0];
                CFG_DIST:   r_dist  <= i_cfg_data;
                CFG_WIDTH:  r_wid   <= i_cfg_data[SCREEN_W-1:0];
                CFG_HEIGHT: r_hgt   <= i_cfg_data[SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    // sine/cosine of the configured angles, held while vertices stream
    vrp_trig u_trig (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (trig_restart),
        .i_yaw     (r_yaw),
        .i_pitch   (r_pitch),
        .o_trig    (trig),
        .o_busy    (trig_busy)
    );

    assign busy = trig_busy;

    // valid bits for the rotate stages
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_vd [SB_LAST+1];

    // stage 1: input capture
    logic signed [15:0] r1_x, r1_y, r1_z;
    logic               r1_last;
    // stage 2: yaw products
    logic signed [31:0] r2_xc, r2_zs, r2_zc, r2_xs;
    logic signed [15:0] r2_y;
    logic               r2_last;
    // stage 3: yaw sums
    logic signed [19:0] r3_camx, r3_z0;
    logic signed [15:0] r3_y;
    logic               r3_last;
    // stage 4: pitch products
    logic signed [31:0] r4_yc, r4_ys;
    logic signed [35:0] r4_zs, r4_zc;
    logic signed [19:0] r4_camx;
    logic               r4_last;
    // stage 5: pitch sums
    logic signed [19:0] r5_camx, r5_camy, r5_camz;
    logic               r5_last;
    // stage 6: depth and x numerator term
    logic signed [20:0] r6_depth;
    logic signed [25:0] r6_t;
    logic signed [19:0] r6_camy;
    // stage 7: scale products
    logic signed [39:0] r7_nx, r7_hd, r7_wy;
    logic [25:0]        r7_den;
    // stage 8: y numerator
    logic signed [39:0] r8_nx, r8_ny;
    logic [25:0]        r8_den;

    t_side r_sb [SB_LAST+1];

    logic signed [24:0] n3_camx, n3_z0, n5_camy, n5_camz;
    logic signed [20:0] n6_depth;
    t_side              n6_side;

    always_comb begin
        n3_camx  = rnd13(38'(r2_xc) + 38'(r2_zs));
        n3_z0    = rnd13(38'(r2_zc) - 38'(r2_xs));
        n5_camy  = rnd13(38'(r4_yc) - 38'(r4_zs));
        n5_camz  = rnd13(38'(r4_ys) + 38'(r4_zc));
        // depth in Q.13: distance is Q.12, so doubled
        n6_depth = 21'(r5_camz) + $signed({4'b0, r_dist, 1'b0});
        n6_side.cam_x = sat16(r5_camx);
        n6_side.cam_y = sat16(r5_camy);
        n6_side.cam_z = sat16(r5_camz);
        n6_side.bad   = (n6_depth <= 21'sd0);
        n6_side.last  = r5_last;
    end

    // valid chain, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            for (int i = 0; i <= SB_LAST; i++) begin
                r_vd[i] <= 1'b0;
            end
        end else begin
            r_v1 <= start & ~busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_vd[0] <= r_v5;
            for (int i = 1; i <= SB_LAST; i++) begin
                r_vd[i] <= r_vd[i-1];
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r1_x    <= i_vertex.vertex_x;
        r1_y    <= i_vertex.vertex_y;
        r1_z    <= i_vertex.vertex_z;
        r1_last <= i_vertex.last_vertex;

        r2_xc   <= r1_x * trig.cos_yaw;
        r2_zs   <= r1_z * trig.sin_yaw;
        r2_zc   <= r1_z * trig.cos_yaw;
        r2_xs   <= r1_x * trig.sin_yaw;
        r2_y    <= r1_y;
        r2_last <= r1_last;

        r3_camx <= n3_camx[19:0];
        r3_z0   <= n3_z0[19:0];
        r3_y    <= r2_y;
        r3_last <= r2_last;

        r4_yc   <= r3_y * trig.cos_pitch;
        r4_zs   <= 36'(r3_z0) * 36'(trig.sin_pitch);
        r4_ys   <= r3_y * trig.sin_pitch;
        r4_zc   <= 36'(r3_z0) * 36'(trig.cos_pitch);
        r4_camx <= r3_camx;
        r4_last <= r3_last;

        r5_camx <= r4_camx;
        r5_camy <= n5_camy[19:0];
        r5_camz <= n5_camz[19:0];
        r5_last <= r4_last;

        // 0.5 and 0.45 as 10/20 and 9/20
        r6_depth <= n6_depth;
        r6_t     <= 26'(n6_depth) * 26'sd10 + 26'(r5_camx) * 26'sd9;
        r6_camy  <= r5_camy;

        r7_nx  <= 40'(r6_t) * 40'($signed({1'b0, r_wid}));
        r7_hd  <= 40'(r6_depth) * 40'($signed({1'b0, r_hgt}));
        r7_wy  <= 40'(r6_camy) * 40'($signed({1'b0, r_wid}));
        r7_den <= 26'($unsigned(r6_depth)) * 26'd20;

        r8_nx  <= r7_nx;
        r8_ny  <= r7_hd * 40'sd10 + r7_wy * 40'sd9;
        r8_den <= r7_den;

        // camera fields and flags ride alongside the quotient pipeline
        r_sb[0] <= n6_side;
        for (int i = 1; i <= SB_LAST; i++) begin
            r_sb[i] <= r_sb[i-1];
        end
    end

    logic signed [15:0] quot_x, quot_y;

    vrp_div u_div_x (
        .i_clk  (i_clk),
        .i_num  (r8_nx),
        .i_den  (r8_den),
        .o_quot (quot_x)
    );

    vrp_div u_div_y (
        .i_clk  (i_clk),
        .i_num  (r8_ny),
        .i_den  (r8_den),
        .o_quot (quot_y)
    );

    // bad depth forces both screen values to the positive limit
    always_comb begin
        o_result_valid     = r_vd[SB_LAST];
        o_result.camera_x  = r_sb[SB_LAST].cam_x;
        o_result.camera_y  = r_sb[SB_LAST].cam_y;
        o_result.camera_z  = r_sb[SB_LAST].cam_z;
        o_result.screen_x  = r_sb[SB_LAST].bad ? 16'sh7fff : quot_x;
        o_result.screen_y  = r_sb[SB_LAST].bad ? 16'sh7fff : quot_y;
        o_result.bad_depth = r_sb[SB_LAST].bad;
        o_result.last_out  = r_sb[SB_LAST].last;
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for vertex_rotate_project: directed vertices with a few
// hand-known results, then random vertices over a series of register
// settings, each result checked field by field against its hand-known value or a built-in predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import vrp_pkg::*;

    localparam int SETTLE     = 40;     // result latency plus margin
    localparam int STALL_MAX  = 4000;   // idle-cycle watchdog limit
    localparam int PHASE_ITEMS = 140;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_vertex   i_vertex;
    logic      o_result_valid;
    t_result   o_result;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    t_cfg_idx  i_cfg_index;
    logic [15:0] i_cfg_data;

    vertex_rotate_project dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_vertex       (i_vertex),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // shadow copy of the configuration registers
    logic [15:0] yaw_reg;
    logic [14:0] pitch_reg;
    logic [15:0] dist_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;

    t_result expected_results[$];
    int      error_count;
    int      vertex_count;
    int      result_count;
    int      bad_depth_count;
    int      idle_cycles;
    bit      allow_idle;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // round to nearest, halves away from zero
    function automatic longint round_drop(longint v, int sh);
        longint half;
        half = longint'(1) <<< (sh - 1);
        if (v >= 0) begin
            return (v + half) >>> sh;
        end
        return -((-v + half) >>> sh);
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) begin
            return 32767;
        end else if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    // parabolic sine with the 0.225 correction, angle in Q.13
    function automatic longint approx_sine(longint ang);
        longint a;
        longint mag;
        longint par;
        longint pmag;
        longint corr;
        a = ang;
        if (a > 25736) begin
            a = a - 51472;
        end
        if (a < -25736) begin
            a = a + 51472;
        end
        mag  = (a < 0) ? -a : a;
        par  = round_drop(a * 83443 * 8192 - a * mag * 26561, 29);
        pmag = (par < 0) ? -par : par;
        corr = round_drop((par * pmag - par * 8192) * 14746, 29);
        return par + corr;
    endfunction

    function automatic t_result project_vertex(t_vertex v);
        t_result r;
        longint yaw, pitch, sy, cy, sp, cp, vx, vy, vz, wid, hgt;
        longint cx, cz0, cyy, cz, depth, sx, sy_scr;
        yaw   = longint'($signed(yaw_reg));
        pitch = longint'($signed(pitch_reg));
        sy = approx_sine(yaw);
        cy = approx_sine(yaw + 12868);
        sp = approx_sine(pitch);
        cp = approx_sine(pitch + 12868);
        vx = longint'(v.vertex_x);
        vy = longint'(v.vertex_y);
        vz = longint'(v.vertex_z);
        wid = longint'(width_reg);
        hgt = longint'(height_reg);
        cx  = round_drop(vx * cy + vz * sy, 13);
        cz0 = round_drop(vz * cy - vx * sy, 13);
        cyy = round_drop(vy * cp - cz0 * sp, 13);
        cz  = round_drop(vy * sp + cz0 * cp, 13);
        depth = cz + 2 * longint'(dist_reg);
        // non-positive depth pins both screen coordinates high
        if (depth <= 0) begin
            sx = 32767;
            sy_scr = 32767;
        end else begin
            sx     = clamp16((wid * (10 * depth + 9 * cx)) / (20 * depth));
            sy_scr = clamp16((10 * hgt * depth + 9 * wid * cyy) / (20 * depth));
        end
        r.camera_x  = 16'(clamp16(cx));
        r.camera_y  = 16'(clamp16(cyy));
        r.camera_z  = 16'(clamp16(cz));
        r.screen_x  = 16'(sx);
        r.screen_y  = 16'(sy_scr);
        r.bad_depth = (depth <= 0);
        r.last_out  = v.last_vertex;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checker: one strobe per result, no backpressure
    // ------------------------------------------------------------------
    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            t_result e;
            result_count++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transaction, actual %h", $time, o_result);
                error_count++;
            end else begin
                e = expected_results.pop_front();
                if (e.bad_depth) bad_depth_count++;
                check_field("camera_x", e.camera_x, o_result.camera_x);
                check_field("camera_y", e.camera_y, o_result.camera_y);
                check_field("camera_z", e.camera_z, o_result.camera_z);
                check_field("screen_x", e.screen_x, o_result.screen_x);
                check_field("screen_y", e.screen_y, o_result.screen_y);
                check_field("bad_depth", e.bad_depth, o_result.bad_depth);
                check_field("last_out", e.last_out, o_result.last_out);
            end
        end
    end

    // watchdog: cycles with no transaction of any kind
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_MAX) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_MAX);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // drivers: change inputs on the falling edge
    // ------------------------------------------------------------------

    // start stays high across back-to-back vertices
    task automatic send_vertex(t_vertex v);
        @(negedge i_clk);
        start    <= 1'b1;
        i_vertex <= v;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(project_vertex(v));
        vertex_count++;
    endtask

    task automatic sender_gap(int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // wait until every result is back, then let the pipeline empty
    task automatic drain();
        sender_gap(1);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_YAW:    yaw_reg    = data;
            CFG_PITCH:  pitch_reg  = data[14:0];
            CFG_DIST:   dist_reg   = data;
            CFG_WIDTH:  width_reg  = data[11:0];
            CFG_HEIGHT: height_reg = data[11:0];
            default: ;  // indexes past the list are ignored
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // writes all five registers; unused upper data bits carry noise
    task automatic write_all(logic [15:0] yaw, logic [14:0] pitch, logic [15:0] dist_val,
                             logic [11:0] wid, logic [11:0] hgt);
        write_reg(CFG_YAW, yaw);
        write_reg(CFG_PITCH, {1'($urandom), pitch});
        write_reg(CFG_DIST, dist_val);
        write_reg(CFG_WIDTH, {4'($urandom), wid});
        write_reg(CFG_HEIGHT, {4'($urandom), hgt});
        // an out-of-range index must change nothing
        write_reg(t_cfg_idx'($urandom_range(5, 7)), 16'($urandom));
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($signed(11'($urandom)));
            2:       return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
            default: return 16'($signed(14'($urandom)));
        endcase
    endfunction

    task automatic random_vertices(int n);
        t_vertex v;
        repeat (n) begin
            if (allow_idle && $urandom_range(0, 9) == 0) begin
                sender_gap($urandom_range(1, 17));
            end
            v.vertex_x    = rand_coord();
            v.vertex_y    = rand_coord();
            v.vertex_z    = rand_coord();
            v.last_vertex = ($urandom_range(0, 7) == 0);
            send_vertex(v);
        end
    endtask

    // ------------------------------------------------------------------
    // directed table: expected result typed in only where obvious
    // ------------------------------------------------------------------
    typedef struct {
        t_vertex v;
        bit      known;
        t_result r;
    } t_vertex_row;

    t_vertex_row directed_rows[$];

    function automatic t_vertex_row row(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                        logic l);
        t_vertex_row d;
        d.v.vertex_x = x;
        d.v.vertex_y = y;
        d.v.vertex_z = z;
        d.v.last_vertex = l;
        d.known = 1'b0;
        d.r = '0;
        return d;
    endfunction

    initial begin
        t_vertex_row d;
        start       = 1'b0;
        i_vertex    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_YAW;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        error_count = 0;
        vertex_count = 0;
        result_count = 0;
        bad_depth_count = 0;
        idle_cycles = 0;
        allow_idle  = 1'b1;
        yaw_reg    = 16'd3277;
        pitch_reg  = 15'(-1638);
        dist_reg   = 16'd14336;
        width_reg  = 12'd960;
        height_reg = 12'd640;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // origin lands on the screen center under reset settings
        d = row(16'h0000, 16'h0000, 16'h0000, 1'b0);
        d.known = 1'b1;
        d.r = '{camera_x: 0, camera_y: 0, camera_z: 0, screen_x: 480, screen_y: 320,
                bad_depth: 1'b0, last_out: 1'b0};
        directed_rows.push_back(d);
        d = row(16'h0000, 16'h0000, 16'h0000, 1'b1);
        d.known = 1'b1;
        d.r = '{camera_x: 0, camera_y: 0, camera_z: 0, screen_x: 480, screen_y: 320,
                bad_depth: 1'b0, last_out: 1'b1};
        directed_rows.push_back(d);
        directed_rows.push_back(row(16'h7fff, 16'h7fff, 16'h7fff, 1'b0));
        directed_rows.push_back(row(16'h8000, 16'h8000, 16'h8000, 1'b1));
        directed_rows.push_back(row(16'h7fff, 16'h8000, 16'h7fff, 1'b0));
        directed_rows.push_back(row(16'h8000, 16'h7fff, 16'h8000, 1'b0));
        directed_rows.push_back(row(16'h7fff, 16'h0000, 16'h0000, 1'b0));
        directed_rows.push_back(row(16'h8000, 16'h0000, 16'h0000, 1'b0));
        directed_rows.push_back(row(16'h0000, 16'h7fff, 16'h0000, 1'b0));
        directed_rows.push_back(row(16'h0000, 16'h8000, 16'h0000, 1'b0));
        // deep negative z: depth goes non-positive
        directed_rows.push_back(row(16'h0000, 16'h0000, 16'h8000, 1'b0));
        directed_rows.push_back(row(16'h0000, 16'h0000, 16'h7fff, 1'b1));
        directed_rows.push_back(row(16'h0001, 16'hffff, 16'h0001, 1'b0));
        directed_rows.push_back(row(16'h5555, 16'haaaa, 16'h5555, 1'b1));

        foreach (directed_rows[i]) begin
            send_vertex(directed_rows[i].v);
            if (directed_rows[i].known) begin
                // replace the predicted entry with the hand-written one
                void'(expected_results.pop_back());
                expected_results.push_back(directed_rows[i].r);
            end
        end
        drain();

        // extreme settings: zero distance, zero-size screen, widest screen,
        // out-of-range pitch both ways, both ends of yaw
        write_all(16'h8000, 15'h4000, 16'd0, 12'd0, 12'd0);
        random_vertices(PHASE_ITEMS);
        drain();
        write_all(16'h7fff, 15'h3fff, 16'hffff, 12'hfff, 12'hfff);
        random_vertices(PHASE_ITEMS);
        drain();
        write_all(16'd0, 15'd9830, 16'd1, 12'd1, 12'd1);
        random_vertices(PHASE_ITEMS);
        drain();
        write_all(16'd25736, 15'(-9830), 16'd4096, 12'd4095, 12'd1);
        random_vertices(PHASE_ITEMS);
        drain();

        // random settings, distance mostly small so bad depth shows up
        repeat (6) begin
            write_all(16'($urandom), 15'($urandom),
                      ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 20000))
                                                  : 16'($urandom),
                      12'($urandom), 12'($urandom));
            random_vertices(PHASE_ITEMS);
            drain();
        end

        // last stretch runs with the sender never idle
        allow_idle = 1'b0;
        random_vertices(PHASE_ITEMS);
        drain();

        $display("covered %0d vertices over 10 register settings plus reset values,",
                 vertex_count);
        $display("%0d results checked, %0d with non-positive depth",
                 result_count, bad_depth_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: vertex_rotate_project.f
hw/rtl/vrp_pkg.sv
hw/rtl/vrp_trig.sv
hw/rtl/vrp_div.sv
hw/rtl/vertex_rotate_project.sv
tb/tb.sv
